/* design/pgl_pkg.sv */
package pgl_pkg;

    // Fixed field widths of the request, response and configuration port
    localparam int SPECIES_W  = 2;
    localparam int INDEX_W    = 15;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS      = 2'd0,
        CFG_LOG2_SIDE = 2'd1,
        CFG_INV_DX2   = 2'd2
    } pgl_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FINAL
    } pgl_state_t;

    typedef struct packed {
        logic                     req_type;
        logic [SPECIES_W-1:0]     species;
        logic [INDEX_W-1:0]       cell_index;
        logic signed [DATA_W-1:0] cell_value;
    } pgl_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] laplacian;
        logic                     saturated;
        logic                     write_done;
    } pgl_rsp_t;

    typedef struct packed {
        logic load;
        logic mem_write;
        logic rd_issue;
        logic take_abs;
        logic mul_lo;
        logic mul_hi;
        logic finish;
    } pgl_cmd_t;

    typedef struct packed {
        logic in_write;
        logic in_sp_ok;
        logic last_tap;
        logic out_free;
    } pgl_status_t;

endpackage

/* design/pgl_stream_if.sv */
interface pgl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/pgl_ctrl.sv */
module pgl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pgl_pkg::pgl_status_t status,
    output pgl_pkg::pgl_cmd_t   cmd
);

    pgl_pkg::pgl_state_t state_reg;
    pgl_pkg::pgl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pgl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (status.in_write)
                        state_next = pgl_pkg::ST_WRITE;
                    else if (status.in_sp_ok)
                        state_next = pgl_pkg::ST_READ;
                    else
                        state_next = pgl_pkg::ST_FINAL;
                end
            end
            pgl_pkg::ST_WRITE:  state_next = pgl_pkg::ST_FINAL;
            pgl_pkg::ST_READ:
            begin
                if (status.last_tap)
                    state_next = pgl_pkg::ST_DRAIN;
            end
            pgl_pkg::ST_DRAIN:  state_next = pgl_pkg::ST_ABS;
            pgl_pkg::ST_ABS:    state_next = pgl_pkg::ST_MUL_LO;
            pgl_pkg::ST_MUL_LO: state_next = pgl_pkg::ST_MUL_HI;
            pgl_pkg::ST_MUL_HI: state_next = pgl_pkg::ST_FINAL;
            pgl_pkg::ST_FINAL:
            begin
                if (status.out_free)
                    state_next = pgl_pkg::ST_IDLE;
            end
            default:            state_next = pgl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == pgl_pkg::ST_IDLE);
        cmd.load      = (state_reg == pgl_pkg::ST_IDLE) && in_valid;
        cmd.mem_write = (state_reg == pgl_pkg::ST_WRITE);
        cmd.rd_issue  = (state_reg == pgl_pkg::ST_READ);
        cmd.take_abs  = (state_reg == pgl_pkg::ST_ABS);
        cmd.mul_lo    = (state_reg == pgl_pkg::ST_MUL_LO);
        cmd.mul_hi    = (state_reg == pgl_pkg::ST_MUL_HI);
        cmd.finish    = (state_reg == pgl_pkg::ST_FINAL) && status.out_free;
    end

    // Single memory port: a write never shares a cycle with a stencil read
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_write && cmd.rd_issue))
        else $error("memory write and read issued together");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("new transaction taken while one is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_lo |=> cmd.mul_hi)
        else $error("high partial product did not follow the low one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_issue && status.last_tap) |=> !cmd.rd_issue)
        else $error("stencil reads continued past the last tap");

endmodule

/* design/pgl_datapath.sv */
module pgl_datapath #(
    parameter int MAX_LOG2_SIDE = 5,
    parameter int MAX_DIMS      = 3,
    parameter int NUM_SPECIES   = 4,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pgl_pkg::pgl_req_t                    req_payload,
    input  logic                                 cfg_we,
    input  logic [pgl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pgl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  pgl_pkg::pgl_cmd_t                    cmd,
    output pgl_pkg::pgl_status_t                 status,
    pgl_stream_if.source                         rsp
);

    localparam int CB      = MAX_LOG2_SIDE * MAX_DIMS;
    localparam int DEPTH   = NUM_SPECIES << CB;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DIM_W   = $clog2(MAX_DIMS + 1);
    localparam int LG_W    = $clog2(MAX_LOG2_SIDE + 1);
    localparam int SH_W    = $clog2(CB + 1);
    localparam int TAP_W   = $clog2(2 * MAX_DIMS + 1);
    localparam int ACC_W   = VALUE_WIDTH + 4;
    localparam int MAG_PAD = (ACC_W > 32) ? ACC_W : 33;
    localparam int HI_W    = MAG_PAD - 32;
    localparam int SAT_W   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int Q_W     = 50;
    localparam logic [Q_W-1:0] POS_LIM = (Q_W'(1) << (SAT_W - 1)) - Q_W'(1);
    localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (SAT_W - 1);

    // Configuration registers
    logic [1:0]  dims_cfg_reg;
    logic [2:0]  lg_cfg_reg;
    logic [31:0] inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_cfg_reg <= 2'd2;
            lg_cfg_reg   <= 3'd5;
            inv_reg      <= 32'd65536;
        end
        else if (cfg_we)
        begin
            unique case (pgl_pkg::pgl_cfg_idx_t'(cfg_index))
                pgl_pkg::CFG_DIMS:      dims_cfg_reg <= cfg_data[1:0];
                pgl_pkg::CFG_LOG2_SIDE: lg_cfg_reg   <= cfg_data[2:0];
                pgl_pkg::CFG_INV_DX2:   inv_reg      <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Effective grid shape and masked cell index of the incoming item
    logic [DIM_W-1:0]       dims_eff;
    logic [LG_W-1:0]        lg_eff;
    logic [SH_W-1:0]        grid_bits;
    logic [CB+pgl_pkg::INDEX_W-1:0] idx_wide;
    logic [CB-1:0]          cell_mask;
    logic [CB-1:0]          cell_in;

    always_comb
    begin
        priority if (dims_cfg_reg == 2'd0)
            dims_eff = DIM_W'(1);
        else if (int'(dims_cfg_reg) > MAX_DIMS)
            dims_eff = DIM_W'(MAX_DIMS);
        else
            dims_eff = DIM_W'(dims_cfg_reg);

        priority if (lg_cfg_reg == 3'd0)
            lg_eff = LG_W'(1);
        else if (int'(lg_cfg_reg) > MAX_LOG2_SIDE)
            lg_eff = LG_W'(MAX_LOG2_SIDE);
        else
            lg_eff = LG_W'(lg_cfg_reg);

        grid_bits = SH_W'(dims_eff) * SH_W'(lg_eff);
        for (int i = 0; i < CB; i++)
        begin
            cell_mask[i] = (SH_W'(i) < grid_bits);
        end
        idx_wide = (CB + pgl_pkg::INDEX_W)'(req_payload.cell_index);
        cell_in  = idx_wide[CB-1:0] & cell_mask;
    end

    assign status.in_write = (req_payload.req_type == pgl_pkg::REQ_WRITE);
    assign status.in_sp_ok = (int'(req_payload.species) < NUM_SPECIES);

    // Captured item
    logic                          is_write_reg;
    logic                          sp_ok_reg;
    logic [pgl_pkg::SPECIES_W-1:0] species_reg;
    logic [CB-1:0]                 cell_reg;
    logic signed [pgl_pkg::DATA_W-1:0] value_reg;
    logic [DIM_W-1:0]              dims_reg;
    logic [LG_W-1:0]               lg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_write_reg <= status.in_write;
            sp_ok_reg    <= status.in_sp_ok;
            species_reg  <= req_payload.species;
            cell_reg     <= cell_in;
            value_reg    <= req_payload.cell_value;
            dims_reg     <= dims_eff;
            lg_reg       <= lg_eff;
        end
    end

    // Stencil address: tap 0 is the centre, then minus/plus pairs per dimension
    logic [TAP_W-1:0]         tap_reg;
    logic [TAP_W-1:0]         tap_m1;
    logic [TAP_W-1:0]         dim_sel;
    logic [SH_W-1:0]          sh;
    logic [MAX_LOG2_SIDE-1:0] side_mask;
    logic [CB-1:0]            cell_sh;
    logic [MAX_LOG2_SIDE-1:0] coord;
    logic [MAX_LOG2_SIDE-1:0] coord_new;
    logic [CB-1:0]            nb_cell;
    logic [CB-1:0]            rd_cell;
    logic [ADDR_W-1:0]        mem_addr;

    always_comb
    begin
        tap_m1  = tap_reg - TAP_W'(1);
        dim_sel = tap_m1 >> 1;
        sh      = SH_W'(dim_sel) * SH_W'(lg_reg);
        for (int i = 0; i < MAX_LOG2_SIDE; i++)
        begin
            side_mask[i] = (LG_W'(i) < lg_reg);
        end
        cell_sh   = cell_reg >> sh;
        coord     = cell_sh[MAX_LOG2_SIDE-1:0] & side_mask;
        coord_new = (tap_m1[0] ? coord + MAX_LOG2_SIDE'(1) : coord - MAX_LOG2_SIDE'(1))
                    & side_mask;
        nb_cell   = (cell_reg & ~(CB'(side_mask) << sh)) | (CB'(coord_new) << sh);
        rd_cell   = (tap_reg == '0) ? cell_reg : nb_cell;
        mem_addr  = ADDR_W'({species_reg, rd_cell});
    end

    assign status.last_tap = (tap_reg == TAP_W'({dims_reg, 1'b0}));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            tap_reg <= '0;
        else if (cmd.rd_issue)
            tap_reg <= tap_reg + TAP_W'(1);
    end

    // Field store, single port with registered read
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic                   mem_we;

    assign mem_we = cmd.mem_write && sp_ok_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= VALUE_WIDTH'(value_reg);
        else if (cmd.rd_issue)
            rdata_reg <= mem[mem_addr];
    end

    logic rd_valid_reg;
    logic rd_centre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            rd_centre_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= cmd.rd_issue;
            rd_centre_reg <= cmd.rd_issue && (tap_reg == '0);
        end
    end

    // Accumulate neighbours, subtract 2*dims times the centre
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] rd_ext;
    logic signed [ACC_W-1:0] centre_w;

    always_comb
    begin
        rd_ext = ACC_W'(signed'(rdata_reg));
        priority if (dims_reg == DIM_W'(1))
            centre_w = rd_ext <<< 1;
        else if (int'(dims_reg) == 2)
            centre_w = rd_ext <<< 2;
        else
            centre_w = (rd_ext <<< 2) + (rd_ext <<< 1);
        acc_next = acc_reg;
        if (rd_valid_reg)
            acc_next = acc_reg + (rd_centre_reg ? -centre_w : rd_ext);
    end

    logic                 neg_reg;
    logic [ACC_W-1:0]     mag_reg;
    logic [MAG_PAD-1:0]   mag_p;
    logic [HI_W-1:0]      mag_hi;
    logic [31:0]          mul_op;
    logic [63:0]          prod;
    logic [63:0]          a_reg;
    logic [63:0]          b_reg;

    assign mag_p  = MAG_PAD'(mag_reg);
    assign mag_hi = mag_p[MAG_PAD-1:32];
    assign mul_op = cmd.mul_hi ? 32'(mag_hi) : mag_p[31:0];
    assign prod   = {32'd0, mul_op} * {32'd0, inv_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
        if (cmd.take_abs)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        end
        if (cmd.mul_lo)
            a_reg <= prod;
        if (cmd.mul_hi)
            b_reg <= prod;
    end

    // Shift by 16 with floor, then clip
    logic                 b_big;
    logic                 round_up;
    logic [Q_W-1:0]       q;
    logic [Q_W-1:0]       q_lim;
    logic                 over;
    logic [Q_W-1:0]       q_clip;
    logic [31:0]          lap_mag;
    pgl_pkg::pgl_rsp_t    rsp_next;

    always_comb
    begin
        b_big    = |b_reg[63:32];
        round_up = neg_reg && (a_reg[15:0] != 16'd0);
        q        = Q_W'({b_reg[31:0], 16'd0}) + Q_W'(a_reg[63:16]) + Q_W'(round_up);
        q_lim    = neg_reg ? NEG_LIM : POS_LIM;
        over     = b_big || (q > q_lim);
        q_clip   = over ? q_lim : q;
        lap_mag  = q_clip[31:0];

        rsp_next.laplacian  = '0;
        rsp_next.saturated  = 1'b0;
        rsp_next.write_done = 1'b0;
        priority if (is_write_reg)
            rsp_next.write_done = 1'b1;
        else if (sp_ok_reg)
        begin
            rsp_next.laplacian = neg_reg ? signed'(-lap_mag) : signed'(lap_mag);
            rsp_next.saturated = over;
        end
    end

    // Output register
    logic              out_valid_reg;
    pgl_pkg::pgl_rsp_t out_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_payload_reg <= rsp_next;
    end

    assign status.out_free = !out_valid_reg || rsp.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.payload     = out_payload_reg;

endmodule

/* design/periodic_grid_laplacian.sv */
// Periodic-grid Laplacian engine.
// req carries one transaction at a time: a write stores a Q16.16 cell value of
// one species, a query asks for the periodic second-difference Laplacian of a
// cell. Every transaction gives exactly one response on rsp: an acknowledge
// (write_done) for a write, or the laplacian and a saturated flag for a query.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the dimension
// count, log2 of the side and the Q16.16 factor 1/dx^2; write it only while no
// transaction is outstanding.
// A write goes through the write state to the output register; a query on an
// unused species goes there straight from idle. For a query, the centre and
// the 2*dims neighbours are read one per cycle from the single-port field
// store, then one 32x32 multiplier forms the two partial products of the
// scaling.
// The next transaction can be taken in the cycle after the previous one has
// reached the output register; a stalled receiver holds the response there
// and the next result waits in the final stage until the register frees up.
// Reset clears the control and restores the configuration defaults (2
// dimensions, side 32, factor 1.0); the field store holds no defined data
// until cells are written.
module periodic_grid_laplacian #(
    parameter int MAX_LOG2_SIDE = 5,
    parameter int MAX_DIMS      = 3,
    parameter int NUM_SPECIES   = 4,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pgl_stream_if.sink                       req,
    pgl_stream_if.source                     rsp,
    input  logic                             cfg_we,
    input  logic [pgl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pgl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    pgl_pkg::pgl_cmd_t    cmd;
    pgl_pkg::pgl_status_t status;

    pgl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pgl_datapath #(
        .MAX_LOG2_SIDE (MAX_LOG2_SIDE),
        .MAX_DIMS      (MAX_DIMS),
        .NUM_SPECIES   (NUM_SPECIES),
        .VALUE_WIDTH   (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_payload (req.payload),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .rsp         (rsp)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_LOG2_SIDE     = 5;
    localparam int MAX_DIMS          = 3;
    localparam int CELLS_PER_SPECIES = 1 << (MAX_LOG2_SIDE * MAX_DIMS);
    localparam int QUERY_LATENCY     = 2 * MAX_DIMS + 7;
    localparam int SETTLE_CYCLES     = QUERY_LATENCY + 4;
    localparam int HOLD_CYCLES       = 300;
    localparam int NUM_PHASES        = 9;
    localparam int PHASE_ITEMS       = 192;
    localparam int NUM_DIRECTED      = 22;
    localparam int CYCLE_LIMIT       = 600000;

    typedef int unsigned cell_list_t[$];

    typedef struct {
        pgl_pkg::pgl_req_t req;
        bit                typed;
        pgl_pkg::pgl_rsp_t rsp;
    } directed_row_t;

    typedef struct packed {
        logic [1:0]  dims;
        logic [2:0]  log2_side;
        logic [31:0] inv_dx2;
        logic        rand_inv;
    } grid_setting_t;

    localparam pgl_pkg::pgl_rsp_t WRITE_ACK =
        '{laplacian: 32'sd0, saturated: 1'b0, write_done: 1'b1};
    localparam pgl_pkg::pgl_rsp_t NO_RSP    = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [pgl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pgl_pkg::CFG_DATA_W-1:0] cfg_data;

    pgl_stream_if #(.payload_t(pgl_pkg::pgl_req_t)) req_if ();
    pgl_stream_if #(.payload_t(pgl_pkg::pgl_rsp_t)) rsp_if ();

    periodic_grid_laplacian u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block's configuration and field store
    logic [1:0]         cur_dims    = 2'd2;
    logic [2:0]         cur_log2    = 3'd5;
    logic [31:0]        cur_inv_dx2 = 32'h0001_0000;
    logic signed [31:0] field_store [int unsigned];

    pgl_pkg::pgl_rsp_t awaited_rsp[$];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          hold_req;
    bit          hold_done;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned n_items;
    int unsigned n_writes;
    int unsigned n_queries;
    int unsigned n_clipped;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd0,      32'h8000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd31,     32'h7FFF_FFFF}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd1,      32'h7FFF_FFFF}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd992,    32'h7FFF_FFFF}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd32,     32'h7FFF_FFFF}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_QUERY, 2'd3, 15'h7C00,   32'h0000_0000}, 1'b1,
          '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd0,      32'h7FFF_FFFF}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd31,     32'h8000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd1,      32'h8000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd992,    32'h8000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd3, 15'd32,     32'h8000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_QUERY, 2'd3, 15'd0,      32'hFFFF_FFFF}, 1'b1,
          '{32'sh8000_0000, 1'b1, 1'b0}},
        '{'{pgl_pkg::REQ_WRITE, 2'd0, 15'h7FFF,   32'h0000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd0, 15'd1022,   32'h0000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd0, 15'd992,    32'h0000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd0, 15'd991,    32'h0000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_WRITE, 2'd0, 15'd31,     32'h0000_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_QUERY, 2'd0, 15'h7FFF,   32'h0000_0000}, 1'b1,
          '{32'sd0, 1'b0, 1'b0}},
        '{'{pgl_pkg::REQ_WRITE, 2'd0, 15'h03FF,   32'h0002_0000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_QUERY, 2'd0, 15'h03FF,   32'hFFFF_FFFF}, 1'b0, NO_RSP},
        '{'{pgl_pkg::REQ_WRITE, 2'd0, 15'd1022,   32'hFFFF_8000}, 1'b1, WRITE_ACK},
        '{'{pgl_pkg::REQ_QUERY, 2'd0, 15'h7FFF,   32'h0000_0000}, 1'b0, NO_RSP}
    };

    grid_setting_t grid_plan [NUM_PHASES] = '{
        '{2'd1, 3'd5, 32'h0001_0000, 1'b0},
        '{2'd3, 3'd2, 32'h0000_4000, 1'b0},
        '{2'd2, 3'd1, 32'hFFFF_FFFF, 1'b0},
        '{2'd0, 3'd0, 32'h0000_0000, 1'b0},
        '{2'd3, 3'd3, 32'h0000_0000, 1'b1},
        '{2'd2, 3'd7, 32'h0001_0000, 1'b0},
        '{2'd3, 3'd5, 32'h0000_1000, 1'b0},
        '{2'd1, 3'd1, 32'hFFFF_FFFF, 1'b0},
        '{2'd2, 3'd4, 32'h0000_0000, 1'b1}
    };

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Store addresses of the centre (first) and its periodic neighbours
    function automatic cell_list_t stencil_cells(input logic [1:0] sp, input logic [14:0] idx);
        cell_list_t  cells;
        int unsigned nd;
        int unsigned lg;
        int unsigned side_mask;
        int unsigned cell_pos;
        int unsigned sh;
        int unsigned c;
        int unsigned base;
        nd = (cur_dims == 2'd0) ? 1 : ((cur_dims > MAX_DIMS) ? MAX_DIMS : cur_dims);
        lg = (cur_log2 == 3'd0) ? 1 : ((cur_log2 > MAX_LOG2_SIDE) ? MAX_LOG2_SIDE : cur_log2);
        side_mask = (1 << lg) - 1;
        cell_pos = idx & ((1 << (nd * lg)) - 1);
        cells.push_back(sp * CELLS_PER_SPECIES + cell_pos);
        for (int unsigned d = 0; d < nd; d++)
        begin
            sh = d * lg;
            c = (cell_pos >> sh) & side_mask;
            base = cell_pos & ~(side_mask << sh);
            cells.push_back(sp * CELLS_PER_SPECIES + (base | (((c - 1) & side_mask) << sh)));
            cells.push_back(sp * CELLS_PER_SPECIES + (base | (((c + 1) & side_mask) << sh)));
        end
        return cells;
    endfunction

    // Apply one transaction to the shadow store and form its response
    function automatic pgl_pkg::pgl_rsp_t stencil_response(input pgl_pkg::pgl_req_t r);
        cell_list_t        taps;
        pgl_pkg::pgl_rsp_t rsp;
        longint            sum;
        int unsigned       nd;
        logic              neg;
        logic [63:0]       mag;
        logic [63:0]       a;
        logic [63:0]       b;
        logic [63:0]       q;
        taps = stencil_cells(r.species, r.cell_index);
        rsp = '0;
        if (r.req_type == pgl_pkg::REQ_WRITE)
        begin
            field_store[taps[0]] = r.cell_value;
            rsp.write_done = 1'b1;
            return rsp;
        end
        nd = (taps.size() - 1) / 2;
        sum = 0;
        for (int i = 1; i < taps.size(); i++)
            sum += longint'(field_store[taps[i]]);
        sum -= longint'(field_store[taps[0]]) * longint'(2 * nd);
        neg = sum < 0;
        mag = neg ? 64'(-sum) : 64'(sum);
        a = {32'd0, mag[31:0]} * {32'd0, cur_inv_dx2};
        b = {32'd0, mag[63:32]} * {32'd0, cur_inv_dx2};
        if (b >= 64'h1_0000_0000)
            q = '1;
        else
        begin
            q = (b << 16) + (a >> 16);
            // round the magnitude up so the signed result is floored
            if (neg && a[15:0] != 16'd0)
                q = q + 1;
        end
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                q = 64'h8000_0000;
                rsp.saturated = 1'b1;
            end
            rsp.laplacian = 32'(64'd0 - q);
        end
        else
        begin
            if (q > 64'h7FFF_FFFF)
            begin
                q = 64'h7FFF_FFFF;
                rsp.saturated = 1'b1;
            end
            rsp.laplacian = q[31:0];
        end
        return rsp;
    endfunction

    function automatic logic [31:0] random_value();
        int v;
        v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        unique case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4: return $urandom;
            default: return v;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(input pgl_pkg::pgl_req_t r, input bit typed,
                         input pgl_pkg::pgl_rsp_t typed_rsp);
        pgl_pkg::pgl_rsp_t exp_rsp;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        exp_rsp = stencil_response(r);
        awaited_rsp.push_back(typed ? typed_rsp : exp_rsp);
        n_items++;
        if (r.req_type == pgl_pkg::REQ_WRITE)
            n_writes++;
        else
            n_queries++;
        @(negedge clk);
    endtask

    task automatic write_reg(input pgl_pkg::pgl_cfg_idx_t idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        unique case (idx)
            pgl_pkg::CFG_DIMS:      cur_dims = data[1:0];
            pgl_pkg::CFG_LOG2_SIDE: cur_log2 = data[2:0];
            pgl_pkg::CFG_INV_DX2:   cur_inv_dx2 = data;
            default:                ;
        endcase
        @(negedge clk);
    endtask

    task automatic settle();
        while (awaited_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Response sink: random back-pressure plus one long hold-off on request
    initial
    begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        pgl_pkg::pgl_rsp_t exp_rsp;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $error("response transaction with nothing outstanding");
                error_count++;
            end
            else
            begin
                exp_rsp = awaited_rsp.pop_front();
                if (rsp_if.payload.laplacian !== exp_rsp.laplacian)
                begin
                    $error("laplacian: expected %h, got %h",
                           exp_rsp.laplacian, rsp_if.payload.laplacian);
                    error_count++;
                end
                if (rsp_if.payload.saturated !== exp_rsp.saturated)
                begin
                    $error("saturated: expected %b, got %b",
                           exp_rsp.saturated, rsp_if.payload.saturated);
                    error_count++;
                end
                if (rsp_if.payload.write_done !== exp_rsp.write_done)
                begin
                    $error("write_done: expected %b, got %b",
                           exp_rsp.write_done, rsp_if.payload.write_done);
                    error_count++;
                end
                if (exp_rsp.saturated)
                    n_clipped++;
            end
        end
    end

    initial
    begin
        pgl_pkg::pgl_req_t r;
        pgl_pkg::pgl_req_t fill;
        cell_list_t        taps;
        grid_setting_t     gs;
        int unsigned       phase_end;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        cfg_we         = 1'b0;
        cfg_index      = pgl_pkg::CFG_DIMS;
        cfg_data       = '0;
        src_idle_pct   = 24;
        snk_idle_pct   = 46;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            gs = grid_plan[p];
            req_if.valid <= 1'b0;
            settle();
            // junk in the unused upper bits must be ignored
            write_reg(pgl_pkg::CFG_DIMS, (32'($urandom) & ~32'h3) | 32'(gs.dims));
            write_reg(pgl_pkg::CFG_LOG2_SIDE, (32'($urandom) & ~32'h7) | 32'(gs.log2_side));
            write_reg(pgl_pkg::CFG_INV_DX2, gs.rand_inv ? 32'($urandom) : gs.inv_dx2);
            cfg_we <= 1'b0;
            src_idle_pct = (p < 3) ? 24 : ((p < 6) ? 46 : 0);
            snk_idle_pct = (p < 3) ? 46 : ((p < 6) ? 24 : 0);
            if (p == 1)
                hold_req = 1'b1;
            phase_end = n_items + PHASE_ITEMS;
            while (n_items < phase_end)
            begin
                r.species    = 2'($urandom_range(0, 3));
                r.cell_index = 15'($urandom_range(0, 32767));
                r.cell_value = random_value();
                r.req_type   = ($urandom_range(0, 99) < 55) ? pgl_pkg::REQ_QUERY
                                                             : pgl_pkg::REQ_WRITE;
                if (r.req_type == pgl_pkg::REQ_QUERY)
                begin
                    // write any unset cell of the stencil before querying it
                    taps = stencil_cells(r.species, r.cell_index);
                    foreach (taps[i])
                    begin
                        if (!field_store.exists(taps[i]))
                        begin
                            fill.req_type   = pgl_pkg::REQ_WRITE;
                            fill.species    = r.species;
                            fill.cell_index = 15'(taps[i] % CELLS_PER_SPECIES);
                            fill.cell_value = random_value();
                            offer(fill, 1'b0, NO_RSP);
                        end
                    end
                end
                offer(r, 1'b0, NO_RSP);
            end
        end

        req_if.valid <= 1'b0;
        settle();
        $display("Covered %0d cell writes and %0d Laplacian queries over %0d grid settings",
                 n_writes, n_queries, NUM_PHASES + 1);
        $display("%0d queries were clipped to the Q16.16 range", n_clipped);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
